>>> hw/rtl/esd_pkg.sv
// Shared types, character codes and UTF-8 helpers for the escaped string decoder.
// No dependencies; the front, the back and the top of the block import this package.
`default_nettype none

package esd_pkg;

    // Character codes used to pick the string mode and to start an escape.
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_BT  = 8'h60;

    // Upper bounds of the one- to five-byte UTF-8 ranges.
    localparam logic [31:0] UTF8_LIM1 = 32'h0000_007F;
    localparam logic [31:0] UTF8_LIM2 = 32'h0000_07FF;
    localparam logic [31:0] UTF8_LIM3 = 32'h0000_FFFF;
    localparam logic [31:0] UTF8_LIM4 = 32'h001F_FFFF;
    localparam logic [31:0] UTF8_LIM5 = 32'h03FF_FFFF;

    // One emission: len 0 is nothing, len 1 is a raw byte in val[7:0],
    // len 2 to 6 is the UTF-8 form of the code point in val.
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] val;
    } t_emit;

    // The work of one input item, handed from the front to the back.
    typedef struct packed {
        logic [2:0]  p_len;
        logic [31:0] p_val;
        logic        s_vld;
        logic [7:0]  s_byte;
        logic        last;
    } t_group;

    function automatic logic [2:0] utf8_len(input logic [31:0] v);
        logic [2:0] n;
        if (v <= UTF8_LIM1)      n = 3'd1;
        else if (v <= UTF8_LIM2) n = 3'd2;
        else if (v <= UTF8_LIM3) n = 3'd3;
        else if (v <= UTF8_LIM4) n = 3'd4;
        else if (v <= UTF8_LIM5) n = 3'd5;
        else                     n = 3'd6;
        return n;
    endfunction

    // A code point with bit 31 set encodes to nothing.
    function automatic t_emit utf8_emission(input logic [31:0] v);
        t_emit e;
        e.val = v;
        e.len = v[31] ? 3'd0 : utf8_len(v);
        return e;
    endfunction

    function automatic t_emit emit_byte(input logic [7:0] b);
        t_emit e;
        e.val = {24'd0, b};
        e.len = 3'd1;
        return e;
    endfunction

    // Hex digit value, or 16 when the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] d;
        if (c >= "0" && c <= "9")      d = {1'b0, c[3:0]};
        else if (c >= "A" && c <= "F") d = 5'(c - "A") + 5'd10;
        else if (c >= "a" && c <= "f") d = 5'(c - "a") + 5'd10;
        else                           d = 5'd16;
        return d;
    endfunction

    // Byte k of an emission of length len.
    function automatic logic [7:0] utf8_byte(input logic [31:0] v, input logic [2:0] len,
                                             input logic [2:0] k);
        logic [2:0]  j;
        logic [31:0] sh;
        logic [7:0]  pre;
        j = len - k - 3'd1;
        case (j)
            3'd0:    sh = v;
            3'd1:    sh = v >> 6;
            3'd2:    sh = v >> 12;
            3'd3:    sh = v >> 18;
            3'd4:    sh = v >> 24;
            3'd5:    sh = v >> 30;
            default: sh = v;
        endcase
        case (len)
            3'd2:    pre = 8'hC0;
            3'd3:    pre = 8'hE0;
            3'd4:    pre = 8'hF0;
            3'd5:    pre = 8'hF8;
            3'd6:    pre = 8'hFC;
            default: pre = 8'h00;
        endcase
        if (k == 3'd0) return pre | sh[7:0];
        else           return {2'b10, sh[5:0]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/esd_front.sv
// Front part of the escaped string decoder: mode selection, escape decoding, length count.
// Depends on esd_pkg; produces at most one group per item for the queue.
`default_nettype none

module esd_front #(
    parameter int  MAX_LEN = 4096,
    localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_first_mark,
    input  logic                 i_last_mark,
    input  logic [7:0]           i_closing_byte,
    output logic                 o_push,
    output esd_pkg::t_group      o_group,
    output logic [CNT_W-1:0]     o_length
);
    import esd_pkg::*;

    localparam int SUM_W = CNT_W + 3;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_STRIP,
        MODE_ESC
    } t_mode;

    typedef enum logic [2:0] {
        ESC_PLAIN,
        ESC_BSLASH,
        ESC_HEX,
        ESC_OCT,
        ESC_UCS
    } t_esc;

    t_mode            r_mode, n_mode;
    t_esc             r_est, n_est, e_st;
    logic [3:0]       r_dl, n_dl, e_dl, dl_inc, dl_dec;
    logic [31:0]      r_code, n_code, e_code, ucs_code;
    logic [7:0]       r_let, n_let, e_let;
    logic [CNT_W-1:0] r_cnt, n_cnt, base, cnt_after;
    logic [8:0]       oct_code;
    logic [7:0]       hex_code;
    logic [4:0]       hv;
    logic             delim, redo, s_vld;
    logic [7:0]       s_byte;
    t_emit            p;
    logic [2:0]       nb;
    logic [SUM_W-1:0] sum;

    // Emission for a digit run that ends before its full length.
    function automatic t_emit flush(input t_esc st, input logic [3:0] dl,
                                    input logic [31:0] code, input logic [7:0] let_c);
        t_emit e;
        logic [3:0] full;
        full = (let_c == "u") ? 4'd4 : 4'd8;
        e = '0;
        case (st)
            ESC_OCT: e = emit_byte(code[7:0]);
            ESC_HEX: e = emit_byte((dl != 4'd0) ? code[7:0] : let_c);
            ESC_UCS: e = (dl != full) ? utf8_emission(code) : emit_byte(let_c);
            default: e = '0;
        endcase
        return e;
    endfunction

    always_comb begin
        // Mode of this item: a first byte chooses it afresh.
        if (i_first_mark) begin
            if ((i_in_byte == CH_SQ || i_in_byte == CH_DQ) && i_in_byte == i_closing_byte)
                n_mode = MODE_STRIP;
            else if (i_in_byte == CH_BT || i_closing_byte == CH_BT)
                n_mode = MODE_ESC;
            else
                n_mode = MODE_PASS;
        end else begin
            n_mode = r_mode;
        end

        e_st   = i_first_mark ? ESC_PLAIN : r_est;
        e_dl   = i_first_mark ? 4'd0 : r_dl;
        e_code = i_first_mark ? 32'd0 : r_code;
        e_let  = i_first_mark ? 8'd0 : r_let;
        base   = i_first_mark ? '0 : r_cnt;
        delim  = i_first_mark | i_last_mark;

        n_est    = e_st;
        n_dl     = e_dl;
        n_code   = e_code;
        n_let    = e_let;
        p        = '0;
        s_vld    = 1'b0;
        s_byte   = 8'd0;
        redo     = 1'b0;
        hv       = hex_val(i_in_byte);
        dl_inc   = e_dl + 4'd1;
        dl_dec   = e_dl - 4'd1;
        oct_code = {e_code[5:0], i_in_byte[2:0]};
        hex_code = {e_code[3:0], hv[3:0]};
        ucs_code = {e_code[27:0], hv[3:0]};

        if (n_mode == MODE_PASS) begin
            p = emit_byte(i_in_byte);
        end else if (!delim) begin
            if (n_mode == MODE_STRIP) begin
                p = emit_byte(i_in_byte);
            end else begin
                case (e_st)
                    ESC_PLAIN: begin
                        if (i_in_byte == CH_BSL) n_est = ESC_BSLASH;
                        else                     p = emit_byte(i_in_byte);
                    end
                    ESC_BSLASH: begin
                        n_est = ESC_PLAIN;
                        n_let = i_in_byte;
                        case (i_in_byte)
                            "a": p = emit_byte(8'd7);
                            "b": p = emit_byte(8'd8);
                            "e": p = emit_byte(8'd27);
                            "f": p = emit_byte(8'd12);
                            "n": p = emit_byte(8'd10);
                            "r": p = emit_byte(8'd13);
                            "t": p = emit_byte(8'd9);
                            "v": p = emit_byte(8'd11);
                            "u": begin
                                n_est  = ESC_UCS;
                                n_dl   = 4'd4;
                                n_code = 32'd0;
                            end
                            "U": begin
                                n_est  = ESC_UCS;
                                n_dl   = 4'd8;
                                n_code = 32'd0;
                            end
                            "x", "X": begin
                                n_est  = ESC_HEX;
                                n_dl   = 4'd0;
                                n_code = 32'd0;
                            end
                            default: begin
                                if (i_in_byte inside {["0":"7"]}) begin
                                    n_est  = ESC_OCT;
                                    n_dl   = 4'd1;
                                    n_code = {29'd0, i_in_byte[2:0]};
                                end else begin
                                    p = emit_byte(i_in_byte);
                                end
                            end
                        endcase
                    end
                    ESC_OCT: begin
                        if (i_in_byte inside {["0":"7"]}) begin
                            n_code = {23'd0, oct_code};
                            n_dl   = dl_inc;
                            if (dl_inc >= 4'd3) begin
                                p     = emit_byte(oct_code[7:0]);
                                n_est = ESC_PLAIN;
                            end
                        end else begin
                            p     = flush(e_st, e_dl, e_code, e_let);
                            n_est = ESC_PLAIN;
                            redo  = 1'b1;
                        end
                    end
                    ESC_HEX: begin
                        if (!hv[4]) begin
                            n_code = {24'd0, hex_code};
                            n_dl   = dl_inc;
                            if (dl_inc >= 4'd2) begin
                                p     = emit_byte(hex_code);
                                n_est = ESC_PLAIN;
                            end
                        end else begin
                            p     = flush(e_st, e_dl, e_code, e_let);
                            n_est = ESC_PLAIN;
                            redo  = 1'b1;
                        end
                    end
                    ESC_UCS: begin
                        if (!hv[4]) begin
                            n_code = ucs_code;
                            n_dl   = dl_dec;
                            if (dl_dec == 4'd0) begin
                                p     = utf8_emission(ucs_code);
                                n_est = ESC_PLAIN;
                            end
                        end else begin
                            p     = flush(e_st, e_dl, e_code, e_let);
                            n_est = ESC_PLAIN;
                            redo  = 1'b1;
                        end
                    end
                    default: begin
                        n_est = ESC_PLAIN;
                        redo  = 1'b1;
                    end
                endcase

                // The byte that ended a digit run is decoded again as plain text.
                if (redo) begin
                    if (i_in_byte == CH_BSL) begin
                        n_est = ESC_BSLASH;
                    end else begin
                        s_vld  = 1'b1;
                        s_byte = i_in_byte;
                    end
                end
            end
        end

        // A run still open at the closing byte is flushed.
        if (i_last_mark && n_mode == MODE_ESC) begin
            p = flush(e_st, e_dl, e_code, e_let);
        end

        nb  = p.len + {2'd0, s_vld};
        sum = SUM_W'(base) + SUM_W'(nb);
        if (sum > SUM_W'(MAX_LEN)) cnt_after = CNT_W'(MAX_LEN);
        else                       cnt_after = sum[CNT_W-1:0];

        n_cnt = cnt_after;
        if (i_last_mark) begin
            n_est  = ESC_PLAIN;
            n_dl   = 4'd0;
            n_code = 32'd0;
            n_let  = 8'd0;
            n_cnt  = '0;
        end

        o_push         = i_take && (nb != 3'd0 || i_last_mark);
        o_group.p_len  = p.len;
        o_group.p_val  = p.val;
        o_group.s_vld  = s_vld;
        o_group.s_byte = s_byte;
        o_group.last   = i_last_mark;
        o_length       = cnt_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_est  <= ESC_PLAIN;
            r_dl   <= 4'd0;
            r_code <= 32'd0;
            r_let  <= 8'd0;
            r_cnt  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_est  <= n_est;
            r_dl   <= n_dl;
            r_code <= n_code;
            r_let  <= n_let;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/esd_queue.sv
// Short first-in first-out queue of decoded groups between the front and the back.
// No package dependency; width and depth come from parameters.
`default_nettype none

module esd_queue #(
    parameter int  WIDTH = 60,
    parameter int  DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/esd_back.sv
// Back part of the escaped string decoder: expands each group into output words.
// Depends on esd_pkg for the group type and the UTF-8 byte helper.
`default_nettype none

module esd_back #(
    parameter int CNT_W = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  esd_pkg::t_group   i_group,
    input  logic [CNT_W-1:0]  i_length,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_data_byte,
    output logic              o_has_byte,
    output logic              o_run_last,
    output logic              o_end_of_string,
    output logic [CNT_W-1:0]  o_out_length
);
    import esd_pkg::*;

    logic [2:0]       r_idx;
    logic             r_out_valid;
    logic [7:0]       r_data;
    logic             r_has, r_run_last, r_eos;
    logic [CNT_W-1:0] r_len;

    logic [2:0] n_tot;
    logic       has, run_end, advance;
    logic [7:0] cur_byte;

    always_comb begin
        n_tot   = i_group.p_len + {2'd0, i_group.s_vld};
        has     = (n_tot != 3'd0);
        run_end = !has || (r_idx + 3'd1 == n_tot);
        if (!has)                       cur_byte = 8'd0;
        else if (r_idx < i_group.p_len) cur_byte = utf8_byte(i_group.p_val, i_group.p_len, r_idx);
        else                            cur_byte = i_group.s_byte;
        advance = i_q_valid && (!r_out_valid || i_out_ready);
        o_pop   = advance && run_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_idx       <= run_end ? 3'd0 : r_idx + 3'd1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data     <= cur_byte;
            r_has      <= has;
            r_run_last <= run_end;
            r_eos      <= run_end && i_group.last;
            r_len      <= (run_end && i_group.last) ? i_length : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_byte     = r_data;
    assign o_has_byte      = r_has;
    assign o_run_last      = r_run_last;
    assign o_end_of_string = r_eos;
    assign o_out_length    = r_len;

endmodule

`default_nettype wire

>>> hw/rtl/escaped_string_decoder_top.sv
// The first word of an item passes through the queue and then the output register.
// Throughput: one item per cycle while the queue has room and items yield at most one word each;
// an item of several words (up to seven, a UTF-8 sequence plus one byte) holds the port until all
// have left. The port moves one word per cycle while i_out_ready holds; the queue absorbs bursts.
// Reset is synchronous and active low; it clears mode, escape state, count and queue at once.
`default_nettype none

module escaped_string_decoder_top #(
    parameter int  MAX_LEN     = 4096,
    parameter int  QUEUE_DEPTH = 4,
    localparam int CNT_W       = $clog2(MAX_LEN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_first_mark,
    input  logic             i_last_mark,
    input  logic [7:0]       i_closing_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_has_byte,
    output logic             o_run_last,
    output logic             o_end_of_string,
    output logic [CNT_W-1:0] o_out_length
);
    import esd_pkg::*;

    // Each queue entry holds one group and the running length after it.
    localparam int Q_W = $bits(t_group) + CNT_W;

    logic             take;
    logic             f_push;
    t_group           f_group;
    logic [CNT_W-1:0] f_length;
    logic [Q_W-1:0]   q_wdata, q_rdata;
    logic             q_full, q_valid, q_pop;
    t_group           q_group;
    logic [CNT_W-1:0] q_length;

    // The front stalls only when the queue is full, never on the output side directly.
    assign o_in_ready = ~q_full;
    assign take       = i_in_valid & o_in_ready;

    // The front decodes one byte per cycle while the queue has room, writing at most one group per item.
    esd_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_in_byte      (i_in_byte),
        .i_first_mark   (i_first_mark),
        .i_last_mark    (i_last_mark),
        .i_closing_byte (i_closing_byte),
        .o_push         (f_push),
        .o_group        (f_group),
        .o_length       (f_length)
    );

    assign q_wdata = {f_group, f_length};

    esd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign q_group  = t_group'(q_rdata[Q_W-1:CNT_W]);
    assign q_length = q_rdata[CNT_W-1:0];

    // The back expands a group into words and keeps them in its output register.
    esd_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_group         (q_group),
        .i_length        (q_length),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_byte     (o_data_byte),
        .o_has_byte      (o_has_byte),
        .o_run_last      (o_run_last),
        .o_end_of_string (o_end_of_string),
        .o_out_length    (o_out_length)
    );

endmodule

`default_nettype wire

>>> tb/sv/escaped_string_decoder_top_tb.sv
// Self-checking testbench for escaped_string_decoder_top: quoted strings go in one byte per word,
// decoded bytes and end-of-string lengths are predicted in a scoreboard class and compared.
// Depends on esd_pkg for the character codes and on the block's RTL.
`timescale 1ns / 1ps

module escaped_string_decoder_top_tb;

    import esd_pkg::*;

    localparam int MAX_LEN       = 4096;
    localparam int RANDOM_ITEMS  = 436;
    localparam int MAX_IDLE      = 18;
    localparam int STALL_LIMIT   = 400;
    localparam int DRAIN_CYCLES  = 12;
    localparam int REPORT_LIMIT  = 10;

    // Decoding mode picked by the opening and closing bytes of a string.
    typedef enum logic [1:0] {
        STR_PASS,
        STR_STRIP,
        STR_ESCAPE
    } str_mode_e;

    // Where the decoder stands inside a backslash escape.
    typedef enum logic [2:0] {
        ESC_TEXT,
        ESC_BACKSLASH,
        ESC_HEX,
        ESC_OCTAL,
        ESC_UNICODE
    } esc_state_e;

    // One input word as the sender presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] close;
    } in_word_t;

    // One output word as the receiver takes it.
    typedef struct packed {
        logic [7:0]  data;
        logic        has;
        logic        run_last;
        logic        eos;
        logic [12:0] len;
    } out_word_t;

    function automatic string describe(out_word_t w);
        return $sformatf("data %02h has %0b run_last %0b end %0b length %0d",
                         w.data, w.has, w.run_last, w.eos, w.len);
    endfunction

    // Tracks the decoder state for every accepted input word and holds the
    // output words still owed by the block.
    class escape_decode_checker;
        str_mode_e   mode;
        esc_state_e  esc;
        logic [3:0]  digits;
        logic [31:0] code;
        logic [7:0]  letter;
        logic [12:0] count;
        logic [7:0]  burst[$];
        out_word_t   owed_words[$];
        int          faults;

        function new();
            mode   = STR_PASS;
            count  = '0;
            faults = 0;
            clear_escape();
        endfunction

        function void clear_escape();
            esc    = ESC_TEXT;
            digits = '0;
            code   = '0;
            letter = '0;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= REPORT_LIMIT) begin
                $display("%t: %s", $realtime, msg);
            end
        endfunction

        // The length counter saturates, but the bytes keep flowing.
        function void push_byte(logic [31:0] b);
            burst.push_back(b[7:0]);
            if (count < MAX_LEN) begin
                count++;
            end
        endfunction

        function void push_utf8(logic [31:0] v);
            int n;
            int j;
            if (v[31]) begin
                return;
            end
            if (v <= 32'h0000_007f)      n = 1;
            else if (v <= 32'h0000_07ff) n = 2;
            else if (v <= 32'h0000_ffff) n = 3;
            else if (v <= 32'h001f_ffff) n = 4;
            else if (v <= 32'h03ff_ffff) n = 5;
            else                         n = 6;
            if (n == 1) begin
                push_byte(v);
                return;
            end
            // The low byte of 0xff00 >> n is the lead prefix: C0, E0, F0, F8 or FC.
            push_byte((32'hff00 >> n) | (v >> (6 * (n - 1))));
            for (j = n - 2; j >= 0; j--) begin
                push_byte(32'h80 | ((v >> (6 * j)) & 32'h3f));
            end
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            return 16;
        endfunction

        // Close a digit run that stops here, as if its last digit had been seen.
        function void flush_run();
            case (esc)
                ESC_OCTAL: push_byte(code);
                ESC_HEX:   push_byte(digits != 0 ? code : {24'd0, letter});
                ESC_UNICODE: begin
                    if (digits != (letter == "u" ? 4'd4 : 4'd8)) push_utf8(code);
                    else push_byte({24'd0, letter});
                end
                default: ;
            endcase
            esc = ESC_TEXT;
        endfunction

        // Returns 1 when the byte ended a run and has to be decoded once more.
        function bit decode_once(logic [7:0] c);
            int d;
            case (esc)
                ESC_TEXT: begin
                    if (c == CH_BSL) esc = ESC_BACKSLASH;
                    else push_byte({24'd0, c});
                    return 0;
                end
                ESC_BACKSLASH: begin
                    esc    = ESC_TEXT;
                    letter = c;
                    case (c)
                        "a": push_byte(32'd7);
                        "b": push_byte(32'd8);
                        "e": push_byte(32'd27);
                        "f": push_byte(32'd12);
                        "n": push_byte(32'd10);
                        "r": push_byte(32'd13);
                        "t": push_byte(32'd9);
                        "v": push_byte(32'd11);
                        "u": begin
                            esc = ESC_UNICODE; digits = 4'd4; code = '0;
                        end
                        "U": begin
                            esc = ESC_UNICODE; digits = 4'd8; code = '0;
                        end
                        "x", "X": begin
                            esc = ESC_HEX; digits = 4'd0; code = '0;
                        end
                        default: begin
                            if (c >= "0" && c <= "7") begin
                                esc    = ESC_OCTAL;
                                digits = 4'd1;
                                code   = {29'd0, c[2:0]};
                            end else begin
                                push_byte({24'd0, c});
                            end
                        end
                    endcase
                    return 0;
                end
                ESC_OCTAL: begin
                    if (c >= "0" && c <= "7") begin
                        code = ((code << 3) + {29'd0, c[2:0]}) & 32'h1ff;
                        digits++;
                        if (digits >= 3) begin
                            push_byte(code);
                            esc = ESC_TEXT;
                        end
                        return 0;
                    end
                    flush_run();
                    return 1;
                end
                ESC_HEX: begin
                    d = hex_value(c);
                    if (d < 16) begin
                        code = ((code << 4) + 32'(d)) & 32'hff;
                        digits++;
                        if (digits >= 2) begin
                            push_byte(code);
                            esc = ESC_TEXT;
                        end
                        return 0;
                    end
                    flush_run();
                    return 1;
                end
                ESC_UNICODE: begin
                    d = hex_value(c);
                    if (d < 16) begin
                        code   = (code << 4) + 32'(d);
                        digits = digits - 4'd1;
                        if (digits == 0) begin
                            push_utf8(code);
                            esc = ESC_TEXT;
                        end
                        return 0;
                    end
                    flush_run();
                    return 1;
                end
                default: begin
                    esc = ESC_TEXT;
                    return 1;
                end
            endcase
        endfunction

        // Work out every output word that one accepted input word causes.
        function void decode_item(in_word_t it);
            bit        delim;
            int        n;
            int        k;
            out_word_t w;
            burst.delete();
            delim = 0;
            if (it.first) begin
                clear_escape();
                count = '0;
                if ((it.data == CH_SQ || it.data == CH_DQ) && it.data == it.close)
                    mode = STR_STRIP;
                else if (it.data == CH_BT || it.close == CH_BT)
                    mode = STR_ESCAPE;
                else
                    mode = STR_PASS;
                delim = 1;
            end
            if (it.last) begin
                delim = 1;
            end
            if (mode == STR_PASS) begin
                push_byte({24'd0, it.data});
            end else if (!delim) begin
                if (mode == STR_ESCAPE) begin
                    if (decode_once(it.data)) begin
                        void'(decode_once(it.data));
                    end
                end else begin
                    push_byte({24'd0, it.data});
                end
            end
            if (it.last && mode == STR_ESCAPE) begin
                flush_run();
            end
            n = burst.size();
            for (k = 0; k < n; k++) begin
                w.data     = burst[k];
                w.has      = 1'b1;
                w.run_last = (k == n - 1);
                w.eos      = it.last && (k == n - 1);
                w.len      = w.eos ? count : '0;
                owed_words.push_back(w);
            end
            if (it.last && n == 0) begin
                w = '{data: 8'h00, has: 1'b0, run_last: 1'b1, eos: 1'b1, len: count};
                owed_words.push_back(w);
            end
            if (it.last) begin
                clear_escape();
                count = '0;
            end
        endfunction

        function void match_word(out_word_t got);
            out_word_t want;
            if (owed_words.size() == 0) begin
                note_fault({"output word with none owed: ", describe(got)});
                return;
            end
            want = owed_words.pop_front();
            if (got != want) begin
                note_fault({"output word mismatch: expected ", describe(want),
                            " actual ", describe(got)});
            end
        endfunction

        function void close_out();
            if (owed_words.size() != 0) begin
                note_fault($sformatf("%0d output words never arrived, oldest: %s",
                                     owed_words.size(), describe(owed_words[0])));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_first_mark;
    logic        i_last_mark;
    logic [7:0]  i_closing_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_data_byte;
    logic        o_has_byte;
    logic        o_run_last;
    logic        o_end_of_string;
    logic [12:0] o_out_length;

    escaped_string_decoder_top #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_first_mark   (i_first_mark),
        .i_last_mark    (i_last_mark),
        .i_closing_byte (i_closing_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_byte    (o_data_byte),
        .o_has_byte     (o_has_byte),
        .o_run_last     (o_run_last),
        .o_end_of_string(o_end_of_string),
        .o_out_length   (o_out_length)
    );

    escape_decode_checker decoder_check;

    // Words of the string being built, sent in order by play_queue.
    in_word_t stim_q[$];

    // When clear, the matching side runs without gaps for the current string.
    bit send_idle;
    bit recv_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus building. The functions here touch nothing but stim_q, to which they append words.
    // ------------------------------------------------------------------

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = any_byte();
        while (b == CH_BSL) b = any_byte();
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'(r) + "0";
        if (r < 16) return 8'(r - 10) + "a";
        return 8'(r - 16) + "A";
    endfunction

    function automatic logic [7:0] named_letter();
        case ($urandom_range(0, 7))
            0:       return "a";
            1:       return "b";
            2:       return "e";
            3:       return "f";
            4:       return "n";
            5:       return "r";
            6:       return "t";
            default: return "v";
        endcase
    endfunction

    function automatic void add_item(logic [7:0] b, logic first, logic last,
                                     logic [7:0] close);
        in_word_t it;
        it = '{data: b, first: first, last: last, close: close};
        stim_q.push_back(it);
    endfunction

    // Body words carry a random closing byte; the block only looks at it on an opening word.
    function automatic void add_body(logic [7:0] b);
        add_item(b, 1'b0, 1'b0, any_byte());
    endfunction

    // One escape sequence, a plain byte or a stray byte inside an escape-mode body.
    function automatic void add_escape_run();
        int n;
        int k;
        case ($urandom_range(0, 9))
            0, 1: add_body(plain_byte());
            2: begin
                add_body(CH_BSL);
                add_body(named_letter());
            end
            3: begin
                add_body(CH_BSL);
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) add_body(8'($urandom_range(0, 7)) + "0");
            end
            4: begin
                add_body(CH_BSL);
                if ($urandom_range(0, 1)) add_body("x");
                else add_body("X");
                n = $urandom_range(0, 2);
                for (k = 0; k < n; k++) add_body(hex_char());
            end
            5: begin
                add_body(CH_BSL);
                add_body("u");
                n = $urandom_range(0, 4);
                for (k = 0; k < n; k++) add_body(hex_char());
            end
            6, 7: begin
                add_body(CH_BSL);
                add_body("U");
                n = $urandom_range(0, 8);
                for (k = 0; k < n; k++) add_body(hex_char());
            end
            8: begin
                add_body(CH_BSL);
                add_body(any_byte());
            end
            default: add_body(any_byte());
        endcase
    endfunction

    function automatic void build_escape_string();
        logic [7:0] open_b;
        logic [7:0] close_b;
        int         segs;
        int         k;
        if ($urandom_range(0, 1)) begin
            open_b  = CH_BT;
            close_b = any_byte();
        end else begin
            open_b  = any_byte();
            close_b = CH_BT;
        end
        if ($urandom_range(0, 11) == 0) begin
            add_item(open_b, 1'b1, 1'b1, close_b);
            return;
        end
        add_item(open_b, 1'b1, 1'b0, close_b);
        segs = $urandom_range(0, 6);
        for (k = 0; k < segs; k++) add_escape_run();
        case ($urandom_range(0, 9))
            // A backslash right before the closing word yields nothing.
            0: add_body(CH_BSL);
            // No closing word: the next opening mark then lands mid-string.
            1: return;
            default: ;
        endcase
        add_item(close_b, 1'b0, 1'b1, any_byte());
    endfunction

    function automatic void build_strip_string();
        logic [7:0] q;
        int         n;
        int         k;
        q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        add_item(q, 1'b1, 1'b0, q);
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) add_body(any_byte());
        add_item(q, 1'b0, 1'b1, any_byte());
    endfunction

    function automatic void build_pass_string();
        logic [7:0] open_b;
        logic [7:0] close_b;
        int         n;
        int         k;
        open_b  = any_byte();
        close_b = any_byte();
        if (open_b == CH_BT) open_b = "P";
        if (close_b == CH_BT) close_b = "Q";
        if ($urandom_range(0, 5) == 0) begin
            add_item(open_b, 1'b1, 1'b1, close_b);
            return;
        end
        add_item(open_b, 1'b1, 1'b0, close_b);
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) add_body(any_byte());
        add_item(close_b, 1'b0, 1'b1, any_byte());
    endfunction

    // Words with random marks: bodies with no opening mark, stray ends, restarts.
    function automatic void build_noise();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
            add_item(any_byte(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                     any_byte());
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving. Inputs change only with nonblocking assignments right after a
    // rising edge; handshakes are judged on the values seen at that edge.
    // ------------------------------------------------------------------

    // Present one word, with a random gap before it, and hold it until taken.
    // Valid is lowered only when a gap follows, so it never drops and rises in
    // the same time step.
    task automatic send_item(in_word_t it);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= it.data;
        i_first_mark   <= it.first;
        i_last_mark    <= it.last;
        i_closing_byte <= it.close;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decoder_check.decode_item(it);
    endtask

    task automatic play_queue();
        while (stim_q.size() > 0) begin
            send_item(stim_q.pop_front());
        end
    endtask

    // Hold the sender back until every owed output word has come out.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decoder_check.owed_words.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: a random stall before each output word, then take it and check it.
    initial begin
        int        stall;
        out_word_t got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = '{data: o_data_byte, has: o_has_byte, run_last: o_run_last,
                    eos: o_end_of_string, len: o_out_length};
            decoder_check.match_word(got);
        end
    end

    // Watchdog: too many cycles in a row without a word moving on either side
    // means the block has hung.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("escaped_string_decoder_top verification failed");
        $finish;
    end

    initial begin
        int rand_items;
        int pick;

        decoder_check = new();
        rand_items    = 0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_byte      <= 8'h00;
        i_first_mark   <= 1'b0;
        i_last_mark    <= 1'b0;
        i_closing_byte <= 8'h00;
        i_out_ready    <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A body byte straight after reset, in pass-through mode.
        add_item(8'h00, 1'b0, 1'b0, 8'h00);
        // One-word strings: pass-through keeps the byte, strip mode gives only
        // the empty end marker.
        add_item(8'hff, 1'b1, 1'b1, 8'h00);
        add_item(CH_DQ, 1'b1, 1'b1, CH_DQ);
        // Backtick string: a three-digit octal that overflows eight bits, \v,
        // a hex escape with no digit, and a bare \u left open at the end.
        add_item(CH_BT, 1'b1, 1'b0, CH_BT);
        add_body(CH_BSL);
        add_body("7");
        add_body("7");
        add_body("7");
        add_body(CH_BSL);
        add_body("v");
        add_body(CH_BSL);
        add_body("x");
        add_body("g");
        add_body(CH_BSL);
        add_body("u");
        add_item(CH_BT, 1'b0, 1'b1, 8'hff);
        // An opening mark in the middle of a pending escape starts a fresh string.
        add_item(CH_BT, 1'b1, 1'b0, CH_BT);
        add_body(CH_BSL);
        add_item(CH_SQ, 1'b1, 1'b0, CH_SQ);
        add_body("Z");
        add_item(CH_SQ, 1'b0, 1'b1, CH_SQ);
        // Only the closing byte is a backtick, and a lone backslash ends the body.
        add_item("A", 1'b1, 1'b0, CH_BT);
        add_body(CH_BSL);
        add_item(CH_BT, 1'b0, 1'b1, CH_BT);
        play_queue();

        // Let everything settle once before the random strings.
        drain_outputs();

        // Random strings, mostly well-formed escape strings with random content,
        // each with its own choice of idling on either side.
        while (rand_items < RANDOM_ITEMS) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 12) build_escape_string();
            else if (pick < 15) build_strip_string();
            else if (pick < 18) build_pass_string();
            else build_noise();
            rand_items += stim_q.size();
            play_queue();
            if ($urandom_range(0, 24) == 0) begin
                drain_outputs();
            end
        end

        // Wait for the last owed word, then a few more cycles for strays.
        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        decoder_check.close_out();

        if (decoder_check.faults == 0) begin
            $display("escaped_string_decoder_top verification clean");
        end else begin
            $display("escaped_string_decoder_top verification failed");
        end
        $finish;
    end

endmodule
